// File: rtl/sofc_pkg.sv
// ----------------------------------------------------------------------------
// sofc_pkg: shared types and constants of the observer feedback controller
// Sizes, fixed-point formats, sequencer operation codes and the command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sofc_pkg;

    localparam int STATE_ORDER       = 4;
    localparam int MEASUREMENT_COUNT = 2;
    localparam int FRACTION_BITS     = 24;
    localparam int NORM_SHIFT        = 32 - FRACTION_BITS;
    localparam int COEF_COUNT        = STATE_ORDER * STATE_ORDER
                                       + STATE_ORDER * MEASUREMENT_COUNT + STATE_ORDER;
    localparam int B_BASE            = STATE_ORDER * STATE_ORDER;
    localparam int C_BASE            = B_BASE + STATE_ORDER * MEASUREMENT_COUNT;
    localparam int ROW_TERMS         = STATE_ORDER + MEASUREMENT_COUNT;

    localparam int ADDR_W = 5;
    localparam int SEL_W  = $clog2(STATE_ORDER);
    localparam int COL_W  = $clog2(ROW_TERMS);
    localparam int ACC_W  = 48;
    localparam int MUL_W  = 33;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_ZERO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN    = 3'd4;

    localparam logic OPC_LOAD   = 1'b0;
    localparam logic OPC_SAMPLE = 1'b1;

    // +10.0 in Q8.24
    localparam logic signed [ACC_W-1:0] TEN = ACC_W'(10) <<< FRACTION_BITS;
    // floor(q/5) == (q*DIV5_MUL) >> DIV5_SHIFT for all 16-bit q
    localparam logic [15:0] DIV5_MUL   = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NORM,
        OP_MAC_X,
        OP_MAC_Y,
        OP_MAC_C,
        OP_GAIN_HI,
        OP_GAIN_LO,
        OP_SAT,
        OP_CODE1,
        OP_CODE2,
        OP_CODE3
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ADDR_W-1:0] addr;
        logic [SEL_W-1:0]  sel;
        logic [SEL_W-1:0]  row;
        logic              first;
        logic              last;
        logic              commit;
        logic              take_item;
        logic              load_out;
    } dp_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/sofc_ctrl.sv
// ----------------------------------------------------------------------------
// sofc_ctrl: sequencer of the observer feedback controller
// Walks normalize, state update, output product, gain, clip and code steps; owns handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sofc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tuser,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output sofc_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_STATE, S_BUB1, S_CMAC, S_BUB2, S_GHI, S_GLO,
        S_SAT, S_C1, S_C2, S_C3, S_DRAIN, S_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [sofc_pkg::SEL_W-1:0]     row_reg, row_next;
    logic [sofc_pkg::COL_W-1:0]     col_reg, col_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic                           out_free;
    logic                           accept;
    logic                           col_is_x;
    logic                           col_last;
    logic                           row_last;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign col_is_x = (col_reg < sofc_pkg::COL_W'(sofc_pkg::STATE_ORDER));
    assign col_last = (col_reg == sofc_pkg::COL_W'(sofc_pkg::ROW_TERMS - 1));
    assign row_last = (row_reg == sofc_pkg::SEL_W'(sofc_pkg::STATE_ORDER - 1));

    always_comb begin
        cmd           = '0;
        cmd.op        = sofc_pkg::OP_NONE;
        cmd.take_item = accept;
        cmd.row       = row_reg;
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                row_next = '0;
                col_next = '0;
                if (accept && s_tuser == sofc_pkg::OPC_SAMPLE) begin
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                cmd.op  = sofc_pkg::OP_NORM;
                cmd.sel = sofc_pkg::SEL_W'(col_reg);
                if (col_reg == sofc_pkg::COL_W'(sofc_pkg::MEASUREMENT_COUNT - 1)) begin
                    col_next   = '0;
                    state_next = S_STATE;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_STATE: begin
                cmd.first = (col_reg == '0);
                cmd.last  = col_last;
                cmd.commit = col_last && row_last;
                if (col_is_x) begin
                    cmd.op   = sofc_pkg::OP_MAC_X;
                    cmd.sel  = sofc_pkg::SEL_W'(col_reg);
                    cmd.addr = sofc_pkg::ADDR_W'(row_reg * sofc_pkg::STATE_ORDER + col_reg);
                end else begin
                    cmd.op   = sofc_pkg::OP_MAC_Y;
                    cmd.sel  = sofc_pkg::SEL_W'(col_reg - sofc_pkg::STATE_ORDER);
                    cmd.addr = sofc_pkg::ADDR_W'(sofc_pkg::B_BASE
                               + row_reg * sofc_pkg::MEASUREMENT_COUNT
                               + col_reg - sofc_pkg::STATE_ORDER);
                end
                if (col_last) begin
                    col_next = '0;
                    if (row_last) begin
                        row_next   = '0;
                        state_next = S_BUB1;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_BUB1: state_next = S_CMAC;
            S_CMAC: begin
                cmd.op    = sofc_pkg::OP_MAC_C;
                cmd.sel   = row_reg;
                cmd.first = (row_reg == '0);
                cmd.addr  = sofc_pkg::ADDR_W'(sofc_pkg::C_BASE + row_reg);
                if (row_last) begin
                    row_next   = '0;
                    state_next = S_BUB2;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_BUB2: state_next = S_GHI;
            S_GHI: begin
                cmd.op     = sofc_pkg::OP_GAIN_HI;
                state_next = S_GLO;
            end
            S_GLO: begin
                cmd.op     = sofc_pkg::OP_GAIN_LO;
                state_next = S_SAT;
            end
            S_SAT: begin
                cmd.op     = sofc_pkg::OP_SAT;
                state_next = S_C1;
            end
            S_C1: begin
                cmd.op     = sofc_pkg::OP_CODE1;
                state_next = S_C2;
            end
            S_C2: begin
                cmd.op     = sofc_pkg::OP_CODE2;
                state_next = S_C3;
            end
            S_C3: begin
                cmd.op     = sofc_pkg::OP_CODE3;
                state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sofc_dp.sv
// ----------------------------------------------------------------------------
// sofc_dp: datapath of the observer feedback controller
// Coefficient store, shared multiplier, accumulator, state vector, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module sofc_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire sofc_pkg::dp_cmd_t                  cmd,
    input  wire logic                               s_tuser,
    input  wire logic [63:0]                        s_tdata,
    input  wire logic                               cfg_wen,
    input  wire logic [sofc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sofc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic [47:0]                             m_tdata,
    output logic                                    m_tuser
);

    localparam int FB = sofc_pkg::FRACTION_BITS;
    localparam int AW = sofc_pkg::ACC_W;
    localparam int MW = sofc_pkg::MUL_W;

    logic [11:0] angle_zero_reg, position_zero_reg;
    logic [31:0] angle_scale_reg, position_scale_reg;
    logic [25:0] output_gain_reg;

    logic signed [31:0] coef_mem [sofc_pkg::COEF_COUNT];
    logic signed [31:0] x_reg [sofc_pkg::STATE_ORDER];
    logic signed [31:0] nx_reg [sofc_pkg::STATE_ORDER];
    logic signed [31:0] y_reg [sofc_pkg::MEASUREMENT_COUNT];

    logic [11:0] angle_raw_reg, position_raw_reg;

    sofc_pkg::dp_cmd_t     cmd_d_reg;
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [2*MW-1:0] prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [AW-1:0]  u_reg;
    logic                  sat_reg;
    logic [16:0]           w_reg;
    logic [29:0]           m_reg;
    logic signed [12:0]    code_reg;

    logic signed [31:0] coef_rd;
    logic signed [12:0] diff;
    logic signed [AW-1:0] term;
    logic signed [AW-1:0] acc_sum;
    logic signed [AW-1:0] norm_val;
    logic [28:0]          v_off;
    logic [40:0]          v_mul;
    logic [30:0]          q_mul;

    logic [4:0]  in_index;
    logic [31:0] in_value;

    assign in_index = s_tdata[4:0];
    assign in_value = s_tdata[36:5];
    assign coef_rd  = coef_mem[cmd.addr];

    // Operand selection for the shared 33x33 signed multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        diff  = '0;
        unique case (cmd.op)
            sofc_pkg::OP_NORM: begin
                if (cmd.sel == '0) begin
                    diff  = $signed({1'b0, angle_raw_reg}) - $signed({1'b0, angle_zero_reg});
                    mul_b = $signed({1'b0, angle_scale_reg});
                end else begin
                    diff  = $signed({1'b0, position_raw_reg})
                            - $signed({1'b0, position_zero_reg});
                    mul_b = $signed({1'b0, position_scale_reg});
                end
                mul_a = MW'(diff);
            end
            sofc_pkg::OP_MAC_X, sofc_pkg::OP_MAC_C: begin
                mul_a = MW'(coef_rd);
                mul_b = MW'(x_reg[cmd.sel]);
            end
            sofc_pkg::OP_MAC_Y: begin
                mul_a = MW'(coef_rd);
                mul_b = MW'(y_reg[cmd.sel[0]]);
            end
            sofc_pkg::OP_GAIN_HI: begin
                mul_a = $signed({7'b0, output_gain_reg});
                mul_b = MW'(acc_reg >>> FB);
            end
            sofc_pkg::OP_GAIN_LO: begin
                mul_a = $signed({7'b0, output_gain_reg});
                mul_b = $signed({9'b0, acc_reg[FB-1:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign term     = AW'(prod_reg >>> FB);
    assign acc_sum  = (cmd_d_reg.first ? AW'(0) : acc_reg) + term;
    assign norm_val = AW'(prod_reg >>> sofc_pkg::NORM_SHIFT);
    assign v_off    = 29'(u_reg + sofc_pkg::TEN);
    assign v_mul    = {v_off, 12'b0} - {12'b0, v_off};
    assign q_mul    = w_reg[16:2] * sofc_pkg::DIV5_MUL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_zero_reg     <= 12'd2036;
            angle_scale_reg    <= 32'd1698523;
            position_zero_reg  <= 12'd2162;
            position_scale_reg <= 32'd2274988;
            output_gain_reg    <= 26'd15099494;
            cmd_d_reg          <= '0;
        end else begin
            cmd_d_reg <= cmd;
            if (cfg_wen) begin
                unique case (cfg_index)
                    sofc_pkg::CFG_ANGLE_ZERO:     angle_zero_reg     <= cfg_wdata[11:0];
                    sofc_pkg::CFG_ANGLE_SCALE:    angle_scale_reg    <= cfg_wdata;
                    sofc_pkg::CFG_POSITION_ZERO:  position_zero_reg  <= cfg_wdata[11:0];
                    sofc_pkg::CFG_POSITION_SCALE: position_scale_reg <= cfg_wdata;
                    sofc_pkg::CFG_OUTPUT_GAIN:    output_gain_reg    <= cfg_wdata[25:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sofc_pkg::STATE_ORDER; i++) begin
                x_reg[i] <= '0;
            end
        end else if (cmd_d_reg.commit) begin
            for (int i = 0; i < sofc_pkg::STATE_ORDER - 1; i++) begin
                x_reg[i] <= nx_reg[i];
            end
            x_reg[sofc_pkg::STATE_ORDER-1] <= sofc_pkg::sat32(acc_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            if (s_tuser == sofc_pkg::OPC_LOAD) begin
                if (in_index < 5'(sofc_pkg::COEF_COUNT)) begin
                    coef_mem[in_index] <= $signed(in_value);
                end
            end else begin
                angle_raw_reg    <= s_tdata[48:37];
                position_raw_reg <= s_tdata[60:49];
            end
        end
        prod_reg <= mul_a * mul_b;
        unique case (cmd_d_reg.op)
            sofc_pkg::OP_NORM: y_reg[cmd_d_reg.sel[0]] <= sofc_pkg::sat32(norm_val);
            sofc_pkg::OP_MAC_X, sofc_pkg::OP_MAC_Y: begin
                acc_reg <= acc_sum;
                if (cmd_d_reg.last) begin
                    nx_reg[cmd_d_reg.row] <= sofc_pkg::sat32(acc_sum);
                end
            end
            sofc_pkg::OP_MAC_C:   acc_reg <= acc_sum;
            sofc_pkg::OP_GAIN_HI: u_reg <= AW'(prod_reg);
            sofc_pkg::OP_GAIN_LO: u_reg <= u_reg + AW'(prod_reg >>> FB);
            sofc_pkg::OP_SAT: begin
                if (u_reg > sofc_pkg::TEN) begin
                    u_reg   <= sofc_pkg::TEN;
                    sat_reg <= 1'b1;
                end else if (u_reg < -sofc_pkg::TEN) begin
                    u_reg   <= -sofc_pkg::TEN;
                    sat_reg <= 1'b1;
                end else begin
                    sat_reg <= 1'b0;
                end
            end
            sofc_pkg::OP_CODE1: w_reg    <= v_mul[40:24];
            sofc_pkg::OP_CODE2: m_reg    <= q_mul[29:0];
            sofc_pkg::OP_CODE3: code_reg <= 13'sd0 - $signed({1'b0, m_reg[29:sofc_pkg::DIV5_SHIFT]});
            default: ;
        endcase
        if (cmd.load_out) begin
            m_tdata <= {6'b0, u_reg[28:0], code_reg};
            m_tuser <= sat_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/state_observer_feedback_controller_unit.sv
// ----------------------------------------------------------------------------
// state_observer_feedback_controller_unit: observer with state feedback
// Top level; joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser = opcode. A load transaction (opcode 0) writes one
//   Q8.24 coefficient (A at 0-15, B at 16-23, C at 24-27) and returns nothing;
//   slots above 27 are dropped. Load all 28 before the first sample.
//   A sample transaction (opcode 1) carries the angle and position readings.
//   Output stream (m_*): one transaction per sample with the converter code,
//   the clipped drive value u and, in tuser, the clip flag.
//   Config port: write cfg_wdata into register cfg_index when cfg_wen is high;
//   write only while the block is idle.
// Timing:
//   A load leaves the sequencer idle. A sample runs from acceptance until m_tvalid
//   rises, with s_tready back in the same cycle: 2 normalize products, 24 state-update
//   multiply-accumulates and 4 output-row products, all through one shared
//   33x33 multiplier with a registered product, then gain and code steps.
//   The finished result sits in an output register, so the next item is taken
//   while it waits; a further result holds in the sequencer until m_tready.
// Reset: aresetn low clears the state vector, restores register defaults and
//   empties the output; the coefficient store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module state_observer_feedback_controller_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: coef_index[4:0], coef_value[36:5], angle_raw[48:37],
    //          position_raw[60:49], zero fill[63:61]
    input  wire logic [63:0]                        s_tdata,
    // s_tuser: opcode
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: command_code[12:0], drive_value[41:13], zero fill[47:42]
    output logic [47:0]                             m_tdata,
    // m_tuser: drive_saturated
    output logic                                    m_tuser,
    input  wire logic                               cfg_wen,
    input  wire logic [sofc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sofc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // command bundle from sequencer to datapath
    sofc_pkg::dp_cmd_t cmd;

    sofc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sofc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: tb/state_observer_feedback_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// state_observer_feedback_controller_unit_tb: self-checking testbench
// Streams coefficient loads and sample pairs into the block and rebuilds every
// drive result with its own fixed-point model of the observer. Configuration
// is rewritten between phases, the extremes among them, while outside burst phases both
// stream sides idle at random, and once the result side holds off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [12:0] code;
    logic [28:0] drive;
    logic        clipped;
} drive_result_t;

class observer_scoreboard;
    logic signed [31:0] coef_store [sofc_pkg::COEF_COUNT];
    logic signed [31:0] state_vec  [sofc_pkg::STATE_ORDER];
    logic [11:0]        angle_zero;
    logic [31:0]        angle_scale;
    logic [11:0]        position_zero;
    logic [31:0]        position_scale;
    logic [25:0]        output_gain;
    drive_result_t      pending_drive [$];
    int                 errors;
    int                 checked;

    function new();
        angle_zero     = 12'd2036;
        angle_scale    = 32'd1698523;
        position_zero  = 12'd2162;
        position_scale = 32'd2274988;
        output_gain    = 26'd15099494;
        foreach (state_vec[i]) state_vec[i] = '0;
        foreach (coef_store[i]) coef_store[i] = '0;
        errors  = 0;
        checked = 0;
    endfunction

    function void set_reg(logic [sofc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            sofc_pkg::CFG_ANGLE_ZERO:     angle_zero     = v[11:0];
            sofc_pkg::CFG_ANGLE_SCALE:    angle_scale    = v;
            sofc_pkg::CFG_POSITION_ZERO:  position_zero  = v[11:0];
            sofc_pkg::CFG_POSITION_SCALE: position_scale = v;
            sofc_pkg::CFG_OUTPUT_GAIN:    output_gain    = v[25:0];
            default: ;
        endcase
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q8.24 product, floored
    function longint fx_mul(longint a, longint b);
        return (a * b) >>> sofc_pkg::FRACTION_BITS;
    endfunction

    function longint scale_reading(logic [11:0] raw, logic [11:0] zero, logic [31:0] scale);
        longint d;
        d = longint'(raw) - longint'(zero);
        return clamp32((d * longint'(scale)) >>> sofc_pkg::NORM_SHIFT);
    endfunction

    function void note_item(logic opc, logic [4:0] idx, logic [31:0] val,
                            logic [11:0] a_raw, logic [11:0] p_raw);
        longint        meas [sofc_pkg::MEASUREMENT_COUNT];
        longint        nxt  [sofc_pkg::STATE_ORDER];
        longint        acc, cx, hi, lo, u, ten, code;
        drive_result_t r;
        if (opc == sofc_pkg::OPC_LOAD) begin
            if (idx < sofc_pkg::COEF_COUNT) coef_store[idx] = val;
            return;
        end
        meas[0] = scale_reading(a_raw, angle_zero, angle_scale);
        meas[1] = scale_reading(p_raw, position_zero, position_scale);
        for (int i = 0; i < sofc_pkg::STATE_ORDER; i++) begin
            acc = 0;
            for (int j = 0; j < sofc_pkg::STATE_ORDER; j++)
                acc += fx_mul(coef_store[i*sofc_pkg::STATE_ORDER+j], state_vec[j]);
            for (int j = 0; j < sofc_pkg::MEASUREMENT_COUNT; j++)
                acc += fx_mul(coef_store[sofc_pkg::B_BASE+i*sofc_pkg::MEASUREMENT_COUNT+j],
                              meas[j]);
            nxt[i] = clamp32(acc);
        end
        foreach (state_vec[i]) state_vec[i] = nxt[i][31:0];
        cx = 0;
        for (int i = 0; i < sofc_pkg::STATE_ORDER; i++)
            cx += fx_mul(coef_store[sofc_pkg::C_BASE+i], state_vec[i]);
        // split cx so that gain*cx never overflows 64 bits
        hi = cx >>> sofc_pkg::FRACTION_BITS;
        lo = cx - (hi <<< sofc_pkg::FRACTION_BITS);
        u  = longint'(output_gain) * hi
             + ((longint'(output_gain) * lo) >>> sofc_pkg::FRACTION_BITS);
        ten = 64'sd10 <<< sofc_pkg::FRACTION_BITS;
        r.clipped = 1'b0;
        if (u > ten) begin
            u = ten;
            r.clipped = 1'b1;
        end else if (u < -ten) begin
            u = -ten;
            r.clipped = 1'b1;
        end
        code    = -(((u + ten) * 4095) / (2 * ten));
        r.code  = code[12:0];
        r.drive = u[28:0];
        pending_drive.push_back(r);
    endfunction

    function void report(string what, longint got, longint want);
        errors++;
        if (errors <= 30) $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endfunction

    function void check(logic [12:0] code, logic [28:0] drive, logic clipped);
        drive_result_t r;
        if (pending_drive.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
        end
        r = pending_drive.pop_front();
        checked++;
        if (code !== r.code) report("command_code", $signed(code), $signed(r.code));
        if (drive !== r.drive) report("drive_value", $signed(drive), $signed(r.drive));
        if (clipped !== r.clipped) report("drive_saturated", clipped, r.clipped);
    endfunction
endclass

module state_observer_feedback_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 50;
    localparam int  PHASES      = 8;
    localparam int  PHASE_ITEMS = 275;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wen = 1'b0;
    logic [sofc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sofc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    observer_scoreboard sb = new();

    int  cycles = 0;
    int  samples_sent = 0;
    int  loads_sent = 0;
    bit  no_idle = 1'b0;     // burst phases: neither side idles
    bit  long_hold_done = 1'b0;
    int  rx_stall = 0;

    state_observer_feedback_controller_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check each transaction, then draw the next stall.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check(m_tdata[12:0], m_tdata[41:13], m_tuser);
            if (!long_hold_done && sb.checked == 150) begin
                // hold off long enough for the input side to back up
                rx_stall       <= 400;
                long_hold_done <= 1'b1;
            end else begin
                rx_stall <= no_idle ? 0 : $urandom_range(0, 5);
            end
        end
    end

    // Drive m_tready away from the sampling edge.
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one transaction and hold it until accepted; then maybe idle.
    task automatic send_item(logic opc, logic [4:0] idx, logic [31:0] val,
                             logic [11:0] a_raw, logic [11:0] p_raw);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = opc;
        s_tdata  = {3'b000, p_raw, a_raw, val, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(opc, idx, val, a_raw, p_raw);
        if (opc == sofc_pkg::OPC_SAMPLE) samples_sent++;
        else loads_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic load_coef(logic [4:0] idx, logic [31:0] val);
        send_item(sofc_pkg::OPC_LOAD, idx, val, 12'($urandom), 12'($urandom));
    endtask

    task automatic send_sample(logic [11:0] a_raw, logic [11:0] p_raw);
        send_item(sofc_pkg::OPC_SAMPLE, 5'($urandom), $urandom, a_raw, p_raw);
    endtask

    task automatic write_reg(logic [sofc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    // Pause the input until every result is back, then let the block settle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_drive.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Mostly modest coefficients so the loop stays in range; a few large ones.
    function automatic logic [31:0] pick_coef(bit is_a);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 6) return is_a ? 32'($urandom_range(0, 1 << 23)) - (1 << 22)
                                   : 32'($urandom_range(0, 1 << 25)) - (1 << 24);
        if (kind <= 8) return 32'($urandom_range(0, 1 << 27)) - (1 << 26);
        return $urandom;
    endfunction

    task automatic set_phase_config(int p);
        case (p)
            1: begin
                write_reg(sofc_pkg::CFG_ANGLE_ZERO, 0);
                write_reg(sofc_pkg::CFG_ANGLE_SCALE, 0);
                write_reg(sofc_pkg::CFG_POSITION_ZERO, 0);
                write_reg(sofc_pkg::CFG_POSITION_SCALE, 0);
                write_reg(sofc_pkg::CFG_OUTPUT_GAIN, 0);
            end
            2: begin
                write_reg(sofc_pkg::CFG_ANGLE_ZERO, 4095);
                write_reg(sofc_pkg::CFG_ANGLE_SCALE, 32'hFFFF_FFFF);
                write_reg(sofc_pkg::CFG_POSITION_ZERO, 4095);
                write_reg(sofc_pkg::CFG_POSITION_SCALE, 32'hFFFF_FFFF);
                write_reg(sofc_pkg::CFG_OUTPUT_GAIN, 33554432);
            end
            3: begin
                write_reg(sofc_pkg::CFG_ANGLE_ZERO, 2036);
                write_reg(sofc_pkg::CFG_ANGLE_SCALE, 1698523);
                write_reg(sofc_pkg::CFG_POSITION_ZERO, 2162);
                write_reg(sofc_pkg::CFG_POSITION_SCALE, 2274988);
                write_reg(sofc_pkg::CFG_OUTPUT_GAIN, 15099494);
            end
            default: begin
                write_reg(sofc_pkg::CFG_ANGLE_ZERO, $urandom_range(0, 4095));
                write_reg(sofc_pkg::CFG_ANGLE_SCALE,
                          ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 24));
                write_reg(sofc_pkg::CFG_POSITION_ZERO, $urandom_range(0, 4095));
                write_reg(sofc_pkg::CFG_POSITION_SCALE,
                          ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 24));
                write_reg(sofc_pkg::CFG_OUTPUT_GAIN, $urandom_range(0, 33554432));
            end
        endcase
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: fill every slot, with 0.5 on the diagonal of A, then extremes.
        for (int i = 0; i < sofc_pkg::COEF_COUNT; i++) begin
            if (i < sofc_pkg::B_BASE)
                load_coef(5'(i), (i % 5 == 0) ? 32'h0080_0000 : 32'h0010_0000);
            else
                load_coef(5'(i), (i % 2 == 0) ? 32'h0100_0000 : 32'hFF80_0000);
        end
        load_coef(5'd28, 32'hDEAD_BEEF);     // out-of-range slots are dropped
        load_coef(5'd31, 32'h1234_5678);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd0, 12'd4095);
        send_sample(12'd2036, 12'd2162);
        load_coef(5'(sofc_pkg::C_BASE), 32'h7FFF_FFFF);   // drive u hard positive
        send_sample(12'd4095, 12'd0);
        load_coef(5'(sofc_pkg::C_BASE), 32'h8000_0000);   // and hard negative
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd0, 12'd0);
        drain();

        for (int p = 1; p < PHASES; p++) begin
            set_phase_config(p);
            no_idle = (p % 3 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 12)
                    load_coef(5'($urandom_range(0, sofc_pkg::COEF_COUNT - 1)),
                              pick_coef($urandom_range(0, 1)));
                else if (r < 14)
                    load_coef(5'($urandom_range(sofc_pkg::COEF_COUNT, 31)), $urandom);
                else if (r < 20)
                    send_sample($urandom_range(0, 1) ? 12'd4095 : 12'd0,
                                $urandom_range(0, 1) ? 12'd4095 : 12'd0);
                else
                    send_sample(12'($urandom), 12'($urandom));
            end
            drain();
        end

        $display("covered %0d samples and %0d coefficient loads over %0d config phases",
                 samples_sent, loads_sent, PHASES);
        $display("checked %0d drive results, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_drive.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
